// ----- design/led_command_packet_parser_unit_assert.svh -----
// Assertion macros for the LED command packet parser checker.
// Needs signals named clock and reset in the scope where a macro is used.
`ifndef LED_COMMAND_PACKET_PARSER_UNIT_ASSERT_SVH
`define LED_COMMAND_PACKET_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define LCPP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lcpp assertion failed");

// next-cycle implication
`define LCPP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lcpp assertion failed");

`endif

// ----- design/lcpp_pkg.sv -----
// Shared types and constants for the LED command packet parser.
// No dependencies; used by the interfaces, the parser core and the top level.
package lcpp_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned IndexWidth = 7;
   localparam int unsigned CsrIdxWidth = 4;

   typedef enum logic [2:0] {
      ACT_NONE     = 3'd0,
      ACT_ACK      = 3'd1,
      ACT_ON       = 3'd2,
      ACT_OFF      = 3'd3,
      ACT_LATCH    = 3'd4,
      ACT_END_LINK = 3'd5,
      ACT_ERR_OUT  = 3'd6,
      ACT_ERR_IN   = 3'd7
   } action_type;

   // register map
   localparam logic [CsrIdxWidth-1:0] REG_START      = 4'd0;
   localparam logic [CsrIdxWidth-1:0] REG_END        = 4'd1;
   localparam logic [CsrIdxWidth-1:0] REG_ACK        = 4'd2;
   localparam logic [CsrIdxWidth-1:0] REG_BEGIN_LINK = 4'd3;
   localparam logic [CsrIdxWidth-1:0] REG_END_LINK   = 4'd4;
   localparam logic [CsrIdxWidth-1:0] REG_LAMP_ON    = 4'd5;
   localparam logic [CsrIdxWidth-1:0] REG_LAMP_OFF   = 4'd6;
   localparam logic [CsrIdxWidth-1:0] REG_LATCH      = 4'd7;

   localparam logic [ByteWidth-1:0] ASCII_ZERO = 8'd48;
   localparam logic [ByteWidth-1:0] ASCII_NINE = 8'd57;

   typedef struct packed {
      logic [ByteWidth-1:0] start_code;
      logic [ByteWidth-1:0] end_code;
      logic [ByteWidth-1:0] ack_code;
      logic [ByteWidth-1:0] begin_link_code;
      logic [ByteWidth-1:0] end_link_code;
      logic [ByteWidth-1:0] lamp_on_code;
      logic [ByteWidth-1:0] lamp_off_code;
      logic [ByteWidth-1:0] latch_code;
   } codes_type;

   localparam codes_type CODES_RESET = '{
      start_code:      8'd2,
      end_code:        8'd3,
      ack_code:        8'd6,
      begin_link_code: 8'd66,
      end_link_code:   8'd69,
      lamp_on_code:    8'd78,
      lamp_off_code:   8'd70,
      latch_code:      8'd83
   };

   typedef struct packed {
      action_type            action;
      logic [IndexWidth-1:0] lamp_index;
   } result_type;

endpackage

// ----- design/lcpp_req_if.sv -----
// Byte input channel interface for the LED command packet parser.
// Depends on lcpp_pkg.
interface lcpp_req_if import lcpp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- design/lcpp_rsp_if.sv -----
// Result channel interface for the LED command packet parser.
// Depends on lcpp_pkg.
interface lcpp_rsp_if import lcpp_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [2:0]            action;
   logic [IndexWidth-1:0] lamp_index;

   modport source (output valid, output action, output lamp_index, input ready);
   modport sink   (input valid, input action, input lamp_index, output ready);
endinterface

// ----- design/lcpp_csr_if.sv -----
// Register write channel interface for the LED command packet parser.
// Depends on lcpp_pkg.
interface lcpp_csr_if import lcpp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CsrIdxWidth-1:0] index;
   logic [ByteWidth-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/lcpp_parser.sv -----
// Parser core: packet state machine and per-byte decode into one result.
// Depends on lcpp_pkg.
module lcpp_parser import lcpp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [ByteWidth-1:0] rx_byte,
   input  codes_type            codes,
   output result_type           result
);

   typedef enum logic [1:0] {
      MODE_OUTSIDE = 2'd0,
      MODE_INSIDE  = 2'd1,
      MODE_DIGIT1  = 2'd2,
      MODE_DIGIT2  = 2'd3
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic       pending_on_ff, pending_on_in;
   logic [3:0] first_digit_ff, first_digit_in;
   logic       first_was_digit_ff, first_was_digit_in;

   logic       is_dec;
   logic [3:0] digit;
   logic [IndexWidth-1:0] two_digit;

   assign is_dec = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
   assign digit  = rx_byte[3:0];
   // first * 10 + second, as shifts and adds
   assign two_digit = {first_digit_ff, 3'b000} + {2'b00, first_digit_ff, 1'b0}
                    + {3'b000, digit};

   always_comb begin
      mode_in            = mode_ff;
      pending_on_in      = pending_on_ff;
      first_digit_in     = first_digit_ff;
      first_was_digit_in = first_was_digit_ff;
      result.action      = ACT_NONE;
      result.lamp_index  = '0;
      unique case (mode_ff)
         MODE_OUTSIDE: begin
            if (rx_byte == codes.ack_code) begin
               result.action = ACT_NONE;
            end else if (rx_byte == codes.start_code) begin
               mode_in = MODE_INSIDE;
            end else begin
               result.action = ACT_ERR_OUT;
            end
         end
         MODE_INSIDE: begin
            if (rx_byte == codes.begin_link_code) begin
               result.action = ACT_NONE;
            end else if (rx_byte == codes.end_link_code) begin
               result.action = ACT_END_LINK;
            end else if (rx_byte == codes.lamp_on_code || rx_byte == codes.lamp_off_code) begin
               pending_on_in = (rx_byte == codes.lamp_on_code);
               mode_in       = MODE_DIGIT1;
            end else if (rx_byte == codes.latch_code) begin
               result.action = ACT_LATCH;
            end else if (rx_byte == codes.end_code) begin
               result.action = ACT_ACK;
               mode_in       = MODE_OUTSIDE;
            end else begin
               result.action = ACT_ERR_IN;
               mode_in       = MODE_OUTSIDE;
            end
         end
         MODE_DIGIT1: begin
            first_was_digit_in = is_dec;
            first_digit_in     = is_dec ? digit : 4'd0;
            mode_in            = MODE_DIGIT2;
         end
         MODE_DIGIT2: begin
            // atoi: stop at the first non-digit
            if (!first_was_digit_ff) begin
               result.lamp_index = '0;
            end else if (is_dec) begin
               result.lamp_index = two_digit;
            end else begin
               result.lamp_index = {3'b000, first_digit_ff};
            end
            result.action = pending_on_ff ? ACT_ON : ACT_OFF;
            mode_in       = MODE_INSIDE;
         end
         default: begin
            mode_in = MODE_OUTSIDE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= MODE_OUTSIDE;
         pending_on_ff      <= 1'b0;
         first_digit_ff     <= '0;
         first_was_digit_ff <= 1'b0;
      end else if (take) begin
         mode_ff            <= mode_in;
         pending_on_ff      <= pending_on_in;
         first_digit_ff     <= first_digit_in;
         first_was_digit_ff <= first_was_digit_in;
      end
   end

endmodule

// ----- design/led_command_packet_parser_unit.sv -----
// Top level of the LED command packet parser: register file, parser core
// and result register. Depends on lcpp_pkg, the channel interfaces, lcpp_parser.
//
//   port      dir   beat carries
//   req_chan  in    rx_byte, one received serial byte
//   rsp_chan  out   action, lamp_index
//   csr_chan  in    index, data (register write)
//
// One byte per cycle while rsp_chan takes results: a byte is decoded in the cycle
// it is accepted and its result shows on rsp_chan the next cycle.
// The result register is the only buffer; req ready drops while it is full
// and not being taken. Synchronous reset restores register defaults and
// closes any open packet. csr writes are always ready.
module led_command_packet_parser_unit import lcpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lcpp_req_if.sink    req_chan,
   lcpp_rsp_if.source  rsp_chan,
   lcpp_csr_if.sink    csr_chan
);

   codes_type             codes_ff;
   logic                  rsp_valid_ff;
   action_type            rsp_action_ff;
   logic [IndexWidth-1:0] rsp_index_ff;

   logic       req_take;
   result_type result;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   lcpp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (req_take),
      .rx_byte (req_chan.rx_byte),
      .codes   (codes_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= CODES_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_START:      codes_ff.start_code      <= csr_chan.data;
            REG_END:        codes_ff.end_code        <= csr_chan.data;
            REG_ACK:        codes_ff.ack_code        <= csr_chan.data;
            REG_BEGIN_LINK: codes_ff.begin_link_code <= csr_chan.data;
            REG_END_LINK:   codes_ff.end_link_code   <= csr_chan.data;
            REG_LAMP_ON:    codes_ff.lamp_on_code    <= csr_chan.data;
            REG_LAMP_OFF:   codes_ff.lamp_off_code   <= csr_chan.data;
            REG_LATCH:      codes_ff.latch_code      <= csr_chan.data;
            default:        codes_ff                 <= codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_action_ff <= result.action;
         rsp_index_ff  <= result.lamp_index;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.action     = rsp_action_ff;
   assign rsp_chan.lamp_index = rsp_index_ff;

endmodule

// ----- design/lcpp_checker.sv -----
// Port-level checker for the LED command packet parser, bound to the top.
// Depends on lcpp_pkg and led_command_packet_parser_unit_assert.svh.
`include "led_command_packet_parser_unit_assert.svh"

module lcpp_checker import lcpp_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [2:0]            action,
   input logic [IndexWidth-1:0] lamp_index
);

   logic is_lamp;
   logic rsp_stall;
   assign is_lamp   = (action == ACT_ON) || (action == ACT_OFF);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // a stalled result beat holds
   `LCPP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(action) && $stable(lamp_index))
   // every accepted byte yields a result beat next cycle
   `LCPP_ASSERT_NEXT(a_one_result, req_valid && req_ready, rsp_valid)
   // LED number only on LED actions
   `LCPP_ASSERT_NOW(a_index_zero, rsp_valid && !is_lamp, lamp_index == '0)
   // two decimal digits at most
   `LCPP_ASSERT_NOW(a_index_range, rsp_valid, lamp_index <= 7'd99)

endmodule

bind led_command_packet_parser_unit lcpp_checker u_lcpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .action     (rsp_chan.action),
   .lamp_index (rsp_chan.lamp_index)
);

// ----- tb/sv/led_command_packet_parser_unit_checker.sv -----
// Result checker for the LED command packet parser: watches the byte, result
// and register channels, tracks the parse state and compares every result beat.
// Depends on lcpp_pkg and the lcpp channel interfaces.
`timescale 1ns / 100ps

module led_command_packet_parser_unit_checker import lcpp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   lcpp_req_if         req_mon,
   lcpp_rsp_if         rsp_mon,
   lcpp_csr_if         csr_mon,
   output int unsigned fail_count,
   output int unsigned results_checked,
   output int unsigned results_waiting
);

   typedef enum logic [1:0] {
      MODE_OUTSIDE,
      MODE_INSIDE,
      MODE_DIGIT1,
      MODE_DIGIT2
   } parse_mode_type;

   codes_type      codes;
   parse_mode_type mode;
   logic           lamp_on_pending;
   logic [3:0]     tens_digit;
   logic           tens_valid;
   result_type     lamp_results_due[$];

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH result %0d %s: got %0d, expected %0d",
               results_checked, what, got, want);
      fail_count++;
   endtask

   function automatic logic is_ascii_digit(input logic [ByteWidth-1:0] b);
      return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
   endfunction

   function automatic void write_code(input logic [CsrIdxWidth-1:0] index,
                                      input logic [ByteWidth-1:0] data);
      case (index)
         REG_START:      codes.start_code      = data;
         REG_END:        codes.end_code        = data;
         REG_ACK:        codes.ack_code        = data;
         REG_BEGIN_LINK: codes.begin_link_code = data;
         REG_END_LINK:   codes.end_link_code   = data;
         REG_LAMP_ON:    codes.lamp_on_code    = data;
         REG_LAMP_OFF:   codes.lamp_off_code   = data;
         REG_LATCH:      codes.latch_code      = data;
         default:        ;
      endcase
   endfunction

   // first matching code wins, in the order the block compares them
   function automatic result_type decode_rx_byte(input logic [ByteWidth-1:0] b);
      result_type  r;
      int unsigned units;
      r.action     = ACT_NONE;
      r.lamp_index = '0;
      case (mode)
         MODE_OUTSIDE: begin
            if (b == codes.ack_code) begin
            end else if (b == codes.start_code) begin
               mode = MODE_INSIDE;
            end else begin
               r.action = ACT_ERR_OUT;
            end
         end
         MODE_INSIDE: begin
            if (b == codes.begin_link_code) begin
            end else if (b == codes.end_link_code) begin
               r.action = ACT_END_LINK;
            end else if (b == codes.lamp_on_code || b == codes.lamp_off_code) begin
               lamp_on_pending = (b == codes.lamp_on_code);
               mode = MODE_DIGIT1;
            end else if (b == codes.latch_code) begin
               r.action = ACT_LATCH;
            end else if (b == codes.end_code) begin
               r.action = ACT_ACK;
               mode = MODE_OUTSIDE;
            end else begin
               r.action = ACT_ERR_IN;
               mode = MODE_OUTSIDE;
            end
         end
         MODE_DIGIT1: begin
            tens_valid = is_ascii_digit(b);
            tens_digit = tens_valid ? 4'(b - ASCII_ZERO) : 4'd0;
            mode = MODE_DIGIT2;
         end
         default: begin
            // atoi style: stop at the first non-digit
            units = b - ASCII_ZERO;
            if (!tens_valid)
               r.lamp_index = '0;
            else if (is_ascii_digit(b))
               r.lamp_index = IndexWidth'(tens_digit * 10 + units);
            else
               r.lamp_index = IndexWidth'(tens_digit);
            r.action = lamp_on_pending ? ACT_ON : ACT_OFF;
            mode = MODE_INSIDE;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_type due;
      if (reset) begin
         codes           = CODES_RESET;
         mode            = MODE_OUTSIDE;
         lamp_on_pending = 1'b0;
         tens_digit      = '0;
         tens_valid      = 1'b0;
         lamp_results_due.delete();
      end else begin
         // retire before pushing: a result never belongs to a byte of the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (lamp_results_due.size() == 0) begin
               report_mismatch("beat with nothing due, action", rsp_mon.action, 0);
            end else begin
               due = lamp_results_due.pop_front();
               if (rsp_mon.action != due.action)
                  report_mismatch("action", rsp_mon.action, due.action);
               if (rsp_mon.lamp_index != due.lamp_index)
                  report_mismatch("lamp_index", rsp_mon.lamp_index, due.lamp_index);
            end
            results_checked++;
         end
         // a byte of the same edge still sees the old codes
         if (req_mon.valid && req_mon.ready)
            lamp_results_due.push_back(decode_rx_byte(req_mon.rx_byte));
         if (csr_mon.valid && csr_mon.ready)
            write_code(csr_mon.index, csr_mon.data);
      end
      results_waiting <= lamp_results_due.size();
   end

endmodule

// ----- tb/sv/led_command_packet_parser_unit_test.sv -----
// Top of the LED command packet parser testbench: clock, reset, byte and
// register stimulus, result back-pressure, watchdog and verdict.
// Depends on lcpp_pkg, the lcpp interfaces, the parser and its checker.
`timescale 1ns / 100ps

module led_command_packet_parser_unit_test import lcpp_pkg::*;;

   localparam int unsigned PhaseCount    = 8;
   localparam int unsigned PhaseItems    = 160;
   localparam int unsigned LatencyPause  = 4;
   localparam int unsigned SqueezeCycles = 120;
   localparam int unsigned IdleLimit     = 2000;
   localparam int unsigned DirectedCount = 25;
   localparam logic [CsrIdxWidth-1:0] REG_UNUSED_FIRST = REG_LATCH + 1'b1;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        squeeze_req = 1'b0;
   logic        sender_calm = 1'b0;
   codes_type   codes_now = CODES_RESET;
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;
   int unsigned fail_count;
   int unsigned results_checked;
   int unsigned results_waiting;

   // defaults: ack, two errors outside, then a packet through every command
   logic [ByteWidth-1:0] directed_bytes [DirectedCount] = '{
      CODES_RESET.ack_code, 8'h00, 8'hFF, CODES_RESET.start_code,
      CODES_RESET.begin_link_code, CODES_RESET.end_link_code,
      CODES_RESET.lamp_on_code, "9", "9",
      CODES_RESET.lamp_off_code, "0", "0",
      CODES_RESET.lamp_on_code, "7", ":",
      CODES_RESET.lamp_off_code, "/", "5",
      CODES_RESET.lamp_on_code, CODES_RESET.end_code, CODES_RESET.start_code,
      CODES_RESET.latch_code, CODES_RESET.end_code,
      CODES_RESET.start_code, 8'hFF
   };

   lcpp_req_if req_chan ();
   lcpp_rsp_if rsp_chan ();
   lcpp_csr_if csr_chan ();

   led_command_packet_parser_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   led_command_packet_parser_unit_checker result_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .csr_mon         (csr_chan),
      .fail_count      (fail_count),
      .results_checked (results_checked),
      .results_waiting (results_waiting)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IdleLimit) @(posedge clock);
      $display("watchdog: no beat on any channel for %0d cycles", idle_cycles);
      $display("led_command_packet_parser_unit_test failed");
      $finish;
   end

   // mostly short, now and then long
   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [ByteWidth-1:0] pick_lamp_digit();
      if ($urandom_range(99) < 85)
         return ASCII_ZERO + 8'($urandom_range(9));
      return 8'($urandom_range(255));
   endfunction

   function automatic codes_type code_setting(input int unsigned phase);
      codes_type c;
      case (phase)
         1: c = '0;
         2: c = '1;
         3: c = '{start_code: 8'h00, end_code: 8'hFF, ack_code: 8'h80,
                  begin_link_code: 8'h01, end_link_code: 8'hFE,
                  lamp_on_code: 8'h30, lamp_off_code: 8'h39, latch_code: 8'h7F};
         // overlaps: end equals start, begin shadows end link, on equals off
         4: c = '{start_code: 8'h01, end_code: 8'h01, ack_code: 8'h02,
                  begin_link_code: 8'h10, end_link_code: 8'h10,
                  lamp_on_code: 8'h20, lamp_off_code: 8'h20, latch_code: 8'h40};
         7: c = CODES_RESET;
         default: c = codes_type'({$urandom(), $urandom()});
      endcase
      return c;
   endfunction

   // receiver: random ready runs and stalls, plus a long hold-off on request
   initial begin
      int unsigned hold_left;
      int unsigned run_left;
      int unsigned stall_left;
      hold_left = 0;
      run_left = 0;
      stall_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (squeeze_req) begin
            squeeze_req <= 1'b0;
            hold_left = SqueezeCycles;
            rsp_chan.ready <= 1'b0;
         end else if (run_left != 0) begin
            run_left--;
            rsp_chan.ready <= 1'b1;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            run_left = ($urandom_range(19) == 0) ? 200 : $urandom_range(1, 12);
            stall_left = gap_length();
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // valid stays high into the next call unless a gap is taken
   task automatic send_rx_byte(input logic [ByteWidth-1:0] b);
      int unsigned gap;
      req_chan.valid <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (!sender_calm) begin
         gap = gap_length();
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic write_register(input logic [CsrIdxWidth-1:0] index,
                                 input logic [ByteWidth-1:0] data);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data <= data;
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   task automatic load_codes(input codes_type c);
      write_register(REG_START, c.start_code);
      write_register(REG_END, c.end_code);
      write_register(REG_ACK, c.ack_code);
      write_register(REG_BEGIN_LINK, c.begin_link_code);
      write_register(REG_END_LINK, c.end_link_code);
      write_register(REG_LAMP_ON, c.lamp_on_code);
      write_register(REG_LAMP_OFF, c.lamp_off_code);
      write_register(REG_LATCH, c.latch_code);
      // past the map: must be dropped, not aliased onto a real register
      write_register(REG_UNUSED_FIRST + CsrIdxWidth'($urandom_range(7)),
                     8'($urandom_range(255)));
      csr_chan.valid <= 1'b0;
      codes_now = c;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_waiting != 0) @(posedge clock);
      repeat (LatencyPause) @(posedge clock);
   endtask

   // mostly well-formed packets with random content, some noise and breakage
   task automatic send_packet();
      int unsigned pick;
      sender_calm = ($urandom_range(7) == 0);
      repeat ($urandom_range(2)) send_rx_byte(codes_now.ack_code);
      if ($urandom_range(11) == 0)
         send_rx_byte(8'($urandom_range(255)));
      send_rx_byte(codes_now.start_code);
      repeat ($urandom_range(1, 6)) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            send_rx_byte(codes_now.begin_link_code);
         end else if (pick < 20) begin
            send_rx_byte(codes_now.end_link_code);
         end else if (pick < 32) begin
            send_rx_byte(codes_now.latch_code);
         end else if (pick < 40) begin
            send_rx_byte(8'($urandom_range(255)));
         end else begin
            send_rx_byte($urandom_range(1) ? codes_now.lamp_on_code
                                           : codes_now.lamp_off_code);
            send_rx_byte(pick_lamp_digit());
            send_rx_byte(pick_lamp_digit());
         end
      end
      if ($urandom_range(9) != 0)
         send_rx_byte(codes_now.end_code);
   endtask

   initial begin
      int unsigned phase_end;
      req_chan.valid = 1'b0;
      req_chan.rx_byte = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_bytes[i])
         send_rx_byte(directed_bytes[i]);

      for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
         if (phase != 0)
            load_codes(code_setting(phase));
         if (phase % 3 == 0)
            squeeze_req <= 1'b1;
         phase_end = items_sent + PhaseItems;
         while (items_sent < phase_end)
            send_packet();
         sender_calm = 1'b0;
         settle();
      end

      $display("covered %0d bytes under %0d code settings, %0d results checked",
               items_sent, PhaseCount, results_checked);
      $display("settings: defaults, all-zero, all-ones, overlapping and random codes");
      if (fail_count == 0)
         $display("led_command_packet_parser_unit_test passed");
      else
         $display("led_command_packet_parser_unit_test failed");
      $finish;
   end

endmodule
